@@ design/bnc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, character codes and register indexes of the bracket nesting
// checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int unsigned SCORE_W = 48;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Bracket characters
  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

  // Bracket kinds as stored on the stack
  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;
  localparam logic [1:0] KIND_ANGLE  = 2'd3;

  // Line status codes
  localparam logic [1:0] LS_BALANCED   = 2'd0;
  localparam logic [1:0] LS_CORRUPT    = 2'd1;
  localparam logic [1:0] LS_INCOMPLETE = 2'd2;
  localparam logic [1:0] LS_OVERFLOW   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ILL_PAREN  = 3'd0;
  localparam logic [2:0] REG_ILL_SQUARE = 3'd1;
  localparam logic [2:0] REG_ILL_CURLY  = 3'd2;
  localparam logic [2:0] REG_ILL_ANGLE  = 3'd3;
  localparam logic [2:0] REG_CMP_PAREN  = 3'd4;
  localparam logic [2:0] REG_CMP_SQUARE = 3'd5;
  localparam logic [2:0] REG_CMP_CURLY  = 3'd6;
  localparam logic [2:0] REG_CMP_ANGLE  = 3'd7;

  // Register reset values
  localparam logic [15:0] ILL_PAREN_RST  = 16'd3;
  localparam logic [15:0] ILL_SQUARE_RST = 16'd57;
  localparam logic [15:0] ILL_CURLY_RST  = 16'd1197;
  localparam logic [15:0] ILL_ANGLE_RST  = 16'd25137;
  localparam logic [7:0]  CMP_PAREN_RST  = 8'd1;
  localparam logic [7:0]  CMP_SQUARE_RST = 8'd2;
  localparam logic [7:0]  CMP_CURLY_RST  = 8'd3;
  localparam logic [7:0]  CMP_ANGLE_RST  = 8'd4;

  typedef struct packed {
    logic       is_open;
    logic       is_close;
    logic [1:0] kind;
  } char_class_t;

  function automatic char_class_t classify(logic [7:0] c);
    char_class_t r;
    r = '0;
    case (c)
      CH_OPEN_PAREN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CH_OPEN_SQUARE:  r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_OPEN_CURLY:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_OPEN_ANGLE:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      CH_CLOSE_PAREN:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CH_CLOSE_SQUARE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CLOSE_CURLY:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      CH_CLOSE_ANGLE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      default:         r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/bnc_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_stack
// Nesting stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bnc_stack #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bnc_unwind.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_unwind
// Completion score accumulator: score = sat48(score * 5 + weight), one step
// per enabled cycle.
// ----------------------------------------------------------------------------
module bnc_unwind
  import bnc_pkg::*;
(
  input  logic               clk_i,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic [7:0]         weight_i,
  output logic [SCORE_W-1:0] score_o
);

  logic [SCORE_W-1:0] score_q, score_d;
  logic [SCORE_W+2:0] sum;

  // x*5 = (x << 2) + x
  assign sum = {1'b0, score_q, 2'b00} + {3'b000, score_q}
             + {{(SCORE_W - 5){1'b0}}, weight_i};

  always_comb begin
    score_d = score_q;
    if (clr_i) begin
      score_d = '0;
    end else if (en_i) begin
      score_d = (|sum[SCORE_W+2:SCORE_W]) ? SCORE_MAX : sum[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
  end

  assign score_o = score_q;

endmodule

@@ design/bracket_nesting_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_nesting_checker
// Checks nesting of (), [], {} and <> per line and reports one result beat
// at the end of each line.
// ----------------------------------------------------------------------------
// Sequence: a byte that pushes or is ignored is taken in S_IDLE; a matching
// closer also passes S_TOP (the new top of stack is read back from the stack
// memory). A byte with line_end goes through S_END and S_OUT whatever it is,
// and also through S_UNWIND and S_DRAIN when the line is incomplete; the
// unwind reads one stack entry per cycle into a single multiply-by-5-and-add
// unit. The result sits in an output register, so the next line can start
// while it waits to be taken; a line end that finds the previous result
// still untaken holds until taken. No clearing pass is needed after reset.
module bracket_nesting_checker
  import bnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // input beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_code_i,
  input  logic               line_end_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         line_status_o,
  output logic [7:0]         illegal_char_o,
  output logic [15:0]        corrupt_points_o,
  output logic [SCORE_W-1:0] completion_score_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TOP    = 6'b000010,
    S_END    = 6'b000100,
    S_UNWIND = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] ill_w_q [4];
  logic [7:0]  cmp_w_q [4];

  logic [LW-1:0] level_q, level_d;
  logic          corrupt_q, corrupt_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    bad_char_q, bad_char_d;
  logic [1:0]    bad_kind_q, bad_kind_d;
  logic [1:0]    top_q, top_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          rd_pend_q, rd_pend_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         status_q, status_d;
  logic [7:0]         ill_char_q, ill_char_d;
  logic [15:0]        points_q, points_d;
  logic [SCORE_W-1:0] score_out_q, score_out_d;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [1:0]    st_rdata;
  logic [LW-1:0] level_m2, level_m1;

  logic               sc_clr, sc_en;
  logic [SCORE_W-1:0] score;

  char_class_t cls;
  logic        active;

  assign cls      = classify(char_code_i);
  assign active   = !corrupt_q && !ovf_q;
  assign level_m1 = level_q - LW'(1);
  assign level_m2 = level_q - LW'(2);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ill_w_q[KIND_PAREN]  <= ILL_PAREN_RST;
      ill_w_q[KIND_SQUARE] <= ILL_SQUARE_RST;
      ill_w_q[KIND_CURLY]  <= ILL_CURLY_RST;
      ill_w_q[KIND_ANGLE]  <= ILL_ANGLE_RST;
      cmp_w_q[KIND_PAREN]  <= CMP_PAREN_RST;
      cmp_w_q[KIND_SQUARE] <= CMP_SQUARE_RST;
      cmp_w_q[KIND_CURLY]  <= CMP_CURLY_RST;
      cmp_w_q[KIND_ANGLE]  <= CMP_ANGLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ILL_PAREN:  ill_w_q[KIND_PAREN]  <= cfg_data_i;
        REG_ILL_SQUARE: ill_w_q[KIND_SQUARE] <= cfg_data_i;
        REG_ILL_CURLY:  ill_w_q[KIND_CURLY]  <= cfg_data_i;
        REG_ILL_ANGLE:  ill_w_q[KIND_ANGLE]  <= cfg_data_i;
        REG_CMP_PAREN:  cmp_w_q[KIND_PAREN]  <= cfg_data_i[7:0];
        REG_CMP_SQUARE: cmp_w_q[KIND_SQUARE] <= cfg_data_i[7:0];
        REG_CMP_CURLY:  cmp_w_q[KIND_CURLY]  <= cfg_data_i[7:0];
        REG_CMP_ANGLE:  cmp_w_q[KIND_ANGLE]  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    corrupt_d   = corrupt_q;
    ovf_d       = ovf_q;
    bad_char_d  = bad_char_q;
    bad_kind_d  = bad_kind_q;
    top_d       = top_q;
    idx_d       = idx_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    ill_char_d  = ill_char_q;
    points_d    = points_q;
    score_out_d = score_out_q;
    st_we       = 1'b0;
    st_waddr    = level_q[AW-1:0];
    // after a pop, the new top sits two below the old level
    st_raddr    = level_m2[AW-1:0];
    sc_clr      = 1'b0;
    sc_en       = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = line_end_i ? S_END : S_IDLE;
          if (active && cls.is_open) begin
            if (level_q == LEVEL_FULL) begin
              ovf_d = 1'b1;
            end else begin
              st_we   = 1'b1;
              level_d = level_q + LW'(1);
              top_d   = cls.kind;
            end
          end else if (active && cls.is_close) begin
            if (level_q != '0 && top_q == cls.kind) begin
              level_d = level_m1;
              if (!line_end_i) begin
                state_d = S_TOP;
              end
            end else begin
              corrupt_d  = 1'b1;
              bad_char_d = char_code_i;
              bad_kind_d = cls.kind;
            end
          end
        end
      end
      S_TOP: begin
        top_d   = st_rdata;
        state_d = S_IDLE;
      end
      S_END: begin
        sc_clr = 1'b1;
        idx_d  = level_m1[AW-1:0];
        if (corrupt_q || ovf_q || level_q == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_UNWIND;
        end
      end
      S_UNWIND: begin
        st_raddr  = idx_q;
        rd_pend_d = 1'b1;
        sc_en     = rd_pend_q;
        if (idx_q == '0) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q - AW'(1);
        end
      end
      S_DRAIN: begin
        sc_en   = rd_pend_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ill_char_d  = '0;
          points_d    = '0;
          score_out_d = '0;
          if (corrupt_q) begin
            status_d   = LS_CORRUPT;
            ill_char_d = bad_char_q;
            points_d   = ill_w_q[bad_kind_q];
          end else if (ovf_q) begin
            status_d = LS_OVERFLOW;
          end else if (level_q == '0) begin
            status_d = LS_BALANCED;
          end else begin
            status_d    = LS_INCOMPLETE;
            score_out_d = score;
          end
          level_d    = '0;
          corrupt_d  = 1'b0;
          ovf_d      = 1'b0;
          bad_char_d = '0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      corrupt_q   <= 1'b0;
      ovf_q       <= 1'b0;
      bad_char_q  <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      corrupt_q   <= corrupt_d;
      ovf_q       <= ovf_d;
      bad_char_q  <= bad_char_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_kind_q  <= bad_kind_d;
    top_q       <= top_d;
    idx_q       <= idx_d;
    status_q    <= status_d;
    ill_char_q  <= ill_char_d;
    points_q    <= points_d;
    score_out_q <= score_out_d;
  end

  bnc_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (cls.kind),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  bnc_unwind u_unwind (
    .clk_i    (clk_i),
    .clr_i    (sc_clr),
    .en_i     (sc_en),
    .weight_i (cmp_w_q[st_rdata]),
    .score_o  (score)
  );

  assign out_valid_o        = out_valid_q;
  assign line_status_o      = status_q;
  assign illegal_char_o     = ill_char_q;
  assign corrupt_points_o   = points_q;
  assign completion_score_o = score_out_q;

endmodule

@@ design/bnc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_checker
// Port-level assertions for the bracket nesting checker, bound to the top.
// ----------------------------------------------------------------------------
module bnc_checker
  import bnc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               line_end_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         line_status_o,
  input logic [7:0]         illegal_char_o,
  input logic [15:0]        corrupt_points_o,
  input logic [SCORE_W-1:0] completion_score_o
);

  // a pending result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_status_o)
      && $stable(completion_score_o))
    else $error("result beat changed while stalled");

  // accepting a line end always makes the checker busy
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && line_end_i |=> !in_ready_o)
    else $error("input taken right after a line end");

  // only a corrupt line carries an illegal closer and its points
  a_corrupt_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_status_o != LS_CORRUPT
      |-> illegal_char_o == 8'd0 && corrupt_points_o == 16'd0)
    else $error("corrupt fields set on a non-corrupt line");

  // only an incomplete line carries a completion score
  a_score_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_status_o != LS_INCOMPLETE |-> completion_score_o == '0)
    else $error("completion score set on a line that is not incomplete");

  // the reported illegal character is always a closer
  a_bad_is_closer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_status_o == LS_CORRUPT
      |-> illegal_char_o == CH_CLOSE_PAREN || illegal_char_o == CH_CLOSE_SQUARE
        || illegal_char_o == CH_CLOSE_CURLY || illegal_char_o == CH_CLOSE_ANGLE)
    else $error("illegal character is not a closing bracket");

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .line_end_i         (line_end_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .line_status_o      (line_status_o),
  .illegal_char_o     (illegal_char_o),
  .corrupt_points_o   (corrupt_points_o),
  .completion_score_o (completion_score_o)
);

@@ tb/sv/bnc_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_tb_pkg
// Line result type and scoreboard for the bracket nesting checker bench. The
// scoreboard tracks the bracket stack of the current line, queues the result
// each line end should give and compares result beats against that queue.
// ----------------------------------------------------------------------------
package bnc_tb_pkg;

  import bnc_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         bad_char;
    logic [15:0]        points;
    logic [SCORE_W-1:0] score;
  } line_result_t;

  class bnc_line_scoreboard #(int DEPTH = 128);

    logic [15:0]  illegal_w[4];
    logic [7:0]   complete_w[4];
    logic [1:0]   nest[DEPTH];
    int           level;
    bit           corrupt;
    bit           overflow;
    logic [7:0]   bad_char;
    line_result_t line_q[$];

    int unsigned  mismatches;
    int unsigned  status_seen[4];
    int unsigned  saturated;

    function new();
      illegal_w[KIND_PAREN]   = ILL_PAREN_RST;
      illegal_w[KIND_SQUARE]  = ILL_SQUARE_RST;
      illegal_w[KIND_CURLY]   = ILL_CURLY_RST;
      illegal_w[KIND_ANGLE]   = ILL_ANGLE_RST;
      complete_w[KIND_PAREN]  = CMP_PAREN_RST;
      complete_w[KIND_SQUARE] = CMP_SQUARE_RST;
      complete_w[KIND_CURLY]  = CMP_CURLY_RST;
      complete_w[KIND_ANGLE]  = CMP_ANGLE_RST;
      clear_line();
    endfunction

    function void clear_line();
      level    = 0;
      corrupt  = 1'b0;
      overflow = 1'b0;
      bad_char = '0;
    endfunction

    // Low two index bits pick the kind within each bank of four registers.
    function void set_weight(logic [2:0] idx, logic [15:0] data);
      if (idx <= REG_ILL_ANGLE) begin
        illegal_w[idx[1:0]] = data;
      end else begin
        complete_w[idx[1:0]] = data[7:0];
      end
    endfunction

    function void decode_char(logic [7:0] c, output bit opener, output bit closer,
                              output logic [1:0] kind);
      opener = 1'b0;
      closer = 1'b0;
      kind   = KIND_PAREN;
      case (c)
        CH_OPEN_PAREN:   begin opener = 1'b1; kind = KIND_PAREN;  end
        CH_OPEN_SQUARE:  begin opener = 1'b1; kind = KIND_SQUARE; end
        CH_OPEN_CURLY:   begin opener = 1'b1; kind = KIND_CURLY;  end
        CH_OPEN_ANGLE:   begin opener = 1'b1; kind = KIND_ANGLE;  end
        CH_CLOSE_PAREN:  begin closer = 1'b1; kind = KIND_PAREN;  end
        CH_CLOSE_SQUARE: begin closer = 1'b1; kind = KIND_SQUARE; end
        CH_CLOSE_CURLY:  begin closer = 1'b1; kind = KIND_CURLY;  end
        CH_CLOSE_ANGLE:  begin closer = 1'b1; kind = KIND_ANGLE;  end
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return line_q.size();
    endfunction

    // One accepted input beat; queues a result when it ends the line.
    function void note_char(logic [7:0] c, logic last);
      bit           op;
      bit           cl;
      logic [1:0]   k;
      line_result_t r;
      logic [63:0]  acc;
      decode_char(c, op, cl, k);
      if (!corrupt && !overflow) begin
        if (op) begin
          if (level >= DEPTH) begin
            overflow = 1'b1;
          end else begin
            nest[level] = k;
            level++;
          end
        end else if (cl) begin
          if (level > 0 && nest[level-1] == k) begin
            level--;
          end else begin
            corrupt  = 1'b1;
            bad_char = c;
          end
        end
      end
      if (!last) return;
      r = '0;
      if (corrupt) begin
        r.status   = LS_CORRUPT;
        r.bad_char = bad_char;
        decode_char(bad_char, op, cl, k);
        r.points   = illegal_w[k];
      end else if (overflow) begin
        r.status = LS_OVERFLOW;
      end else if (level == 0) begin
        r.status = LS_BALANCED;
      end else begin
        r.status = LS_INCOMPLETE;
        acc = '0;
        // unwind top to bottom, clamping at the 48-bit ceiling
        for (int i = level - 1; i >= 0; i--) begin
          acc = acc * 5 + complete_w[nest[i]];
          if (acc > SCORE_MAX) acc = SCORE_MAX;
        end
        r.score = acc[SCORE_W-1:0];
      end
      line_q.insert(line_q.size(), r);
      clear_line();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_line(line_result_t got);
      line_result_t want;
      if (line_q.size() == 0) begin
        report_mismatch($sformatf("result beat with no line pending (status %0d)",
                                  got.status));
        return;
      end
      want = line_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("line_status %0d, want %0d", got.status, want.status));
      if (got.bad_char !== want.bad_char)
        report_mismatch($sformatf("illegal_char 0x%0h, want 0x%0h",
                                  got.bad_char, want.bad_char));
      if (got.points !== want.points)
        report_mismatch($sformatf("corrupt_points %0d, want %0d", got.points, want.points));
      if (got.score !== want.score)
        report_mismatch($sformatf("completion_score 0x%0h, want 0x%0h",
                                  got.score, want.score));
      status_seen[want.status]++;
      if (want.status == LS_INCOMPLETE && want.score == SCORE_MAX) saturated++;
    endtask

  endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the bracket nesting checker. Directed lines hit the special cases,
// then random lines (nested, broken, deep and noisy) run under four weight
// settings with random gaps on both handshakes; every result beat is checked
// against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  import bnc_pkg::*;
  import bnc_tb_pkg::*;

  localparam int          STACK_DEPTH  = 128;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned PHASES       = 4;
  // worst line end: a full unwind of the stack plus margin
  localparam int unsigned DRAIN_CYCLES = STACK_DEPTH + 24;

  localparam logic [2:0] REG_ORDER[8] = '{REG_ILL_PAREN, REG_ILL_SQUARE, REG_ILL_CURLY,
                                          REG_ILL_ANGLE, REG_CMP_PAREN, REG_CMP_SQUARE,
                                          REG_CMP_CURLY, REG_CMP_ANGLE};

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [2:0]         cfg_idx_i   = '0;
  logic [15:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [7:0]         char_code_i = '0;
  logic               line_end_i  = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         line_status_o;
  logic [7:0]         illegal_char_o;
  logic [15:0]        corrupt_points_o;
  logic [SCORE_W-1:0] completion_score_o;

  bnc_line_scoreboard #(.DEPTH(STACK_DEPTH)) sb;

  bit          rst_done;
  bit          steady;      // no idling on either side for the current line
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned lines_sent;
  logic [7:0]  line_buf[$];

  bracket_nesting_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .char_code_i,
    .line_end_i,
    .out_valid_o,
    .out_ready_i,
    .line_status_o,
    .illegal_char_o,
    .corrupt_points_o,
    .completion_score_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines still pending", cycle_count,
               sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- bracket helpers ----------------

  function automatic logic [7:0] opener_of(logic [1:0] k);
    case (k)
      KIND_PAREN:  return CH_OPEN_PAREN;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY:  return CH_OPEN_CURLY;
      default:     return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(logic [1:0] k);
    case (k)
      KIND_PAREN:  return CH_CLOSE_PAREN;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY:  return CH_CLOSE_CURLY;
      default:     return CH_CLOSE_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] any_bracket();
    logic [1:0] k;
    k = 2'($urandom_range(0, 3));
    return $urandom_range(0, 1) ? opener_of(k) : closer_of(k);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    bit         op;
    bit         cl;
    logic [1:0] k;
    do begin
      c = 8'($urandom_range(0, 255));
      sb.decode_char(c, op, cl, k);
    end while (op || cl);
    return c;
  endfunction

  // appends one byte to the line under construction
  function automatic void add_byte(logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  // ---------------- drivers ----------------

  // Valid stays high across back-to-back beats; it drops only for a gap.
  task automatic send_char(logic [7:0] c, logic last);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    line_end_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_char(c, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    steady = ($urandom_range(0, 3) == 0);
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
  endtask

  // Wait for every queued result, then let the block settle.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_weights(logic [15:0] vals[8]);
    foreach (REG_ORDER[i]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_ORDER[i];
      cfg_data_i <= vals[i];
      sb.set_weight(REG_ORDER[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed nesting with random content, plus deep pushes up to
  // and past the stack size, plus plain byte noise.
  task automatic build_random_line();
    logic [1:0]  open_k[$];
    logic [1:0]  k;
    int unsigned pick;
    int unsigned cap;
    int unsigned n;
    line_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      cap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat ($urandom_range(1, 30)) begin
        if ($urandom_range(0, 7) == 0) begin
          add_byte(plain_char());
        end else if (open_k.size() == 0 || (open_k.size() < cap && $urandom_range(0, 1))) begin
          k = 2'($urandom_range(0, 3));
          open_k = {open_k, k};
          add_byte(opener_of(k));
        end else begin
          add_byte(closer_of(open_k.pop_back()));
        end
      end
      case ($urandom_range(0, 2))
        0: while (open_k.size() != 0) add_byte(closer_of(open_k.pop_back()));
        1: ;  // leave it open
        default: begin
          // wrong closer (or a closer on an empty stack), then ignored tail
          k = (open_k.size() != 0) ? open_k[$] + 2'($urandom_range(1, 3))
                                   : 2'($urandom_range(0, 3));
          add_byte(closer_of(k));
          repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
      if ($urandom_range(0, 3) == 0) add_byte(plain_char());
    end else if (pick < 66) begin
      case ($urandom_range(0, 3))
        0: n = STACK_DEPTH - 1;
        1: n = STACK_DEPTH;
        2: n = STACK_DEPTH + 1;
        default: n = $urandom_range(20, STACK_DEPTH + 4);
      endcase
      repeat (n) add_byte(opener_of(2'($urandom_range(0, 3))));
      repeat ($urandom_range(0, 3)) add_byte(any_bracket());
    end else begin
      repeat ($urandom_range(1, 12))
        add_byte($urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------- result side ----------------

  initial begin
    int unsigned  stall;
    line_result_t got;
    wait (rst_done);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      got = '{status: line_status_o, bad_char: illegal_char_o,
              points: corrupt_points_o, score: completion_score_o};
      sb.check_line(got);
      @(negedge clk_i);
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    logic [15:0] vals[8];
    int unsigned phase_bytes;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni   <= 1'b1;
    rst_done = 1'b1;
    @(negedge clk_i);

    // directed lines at reset weights
    line_buf = '{8'h00};
    send_line();
    line_buf = '{8'hFF, CH_OPEN_SQUARE, CH_OPEN_ANGLE};
    send_line();
    line_buf = '{CH_CLOSE_PAREN};
    send_line();
    line_buf = '{CH_OPEN_CURLY, CH_CLOSE_SQUARE, CH_OPEN_PAREN};
    send_line();
    line_buf = '{CH_OPEN_PAREN, CH_CLOSE_CURLY};
    send_line();
    line_buf = '{CH_OPEN_SQUARE, CH_CLOSE_ANGLE};
    send_line();
    line_buf = '{CH_OPEN_ANGLE, CH_OPEN_CURLY, CH_CLOSE_CURLY, CH_CLOSE_ANGLE};
    send_line();
    line_buf = '{CH_OPEN_PAREN, CH_CLOSE_PAREN, CH_OPEN_SQUARE, CH_CLOSE_SQUARE};
    send_line();
    line_buf = '{CH_OPEN_CURLY, CH_OPEN_PAREN};
    send_line();

    // reset weights, then all ones, all zeros, random
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        quiesce();
        foreach (vals[i]) begin
          case (phase)
            1:       vals[i] = '1;
            2:       vals[i] = '0;
            default: vals[i] = 16'($urandom);
          endcase
        end
        write_weights(vals);
      end
      phase_bytes = 0;
      while (phase_bytes < RANDOM_ITEMS / PHASES) begin
        build_random_line();
        send_line();
        phase_bytes += line_buf.size();
      end
    end

    quiesce();
    $display("ran %0d bytes in %0d lines over %0d weight settings", bytes_sent,
             lines_sent, PHASES);
    $display("lines: %0d balanced, %0d corrupt, %0d incomplete (%0d saturated), %0d overflow",
             sb.status_seen[LS_BALANCED], sb.status_seen[LS_CORRUPT],
             sb.status_seen[LS_INCOMPLETE], sb.saturated, sb.status_seen[LS_OVERFLOW]);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
